// File: sv/sfscp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfscp_pkg
// Shared constants and types for the sync-header frame parser.
// ----------------------------------------------------------------------------
package sfscp_pkg;

    localparam int PAYLOAD_BYTES = 32;
    localparam int FRAME_SLOTS   = 16;

    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam int SLOT_W = $clog2(FRAME_SLOTS);

    localparam int RX_BYTE_W    = 8;
    localparam int CHANNEL_W    = 5;
    localparam int SAMPLE_W     = 8;
    localparam int FRAME_SLOT_W = 4;

    localparam logic [7:0] SYNC_FIRST   = 8'h55;
    localparam logic [7:0] SYNC_SECOND  = 8'hAA;
    localparam logic [7:0] TYPE_DATA    = 8'h0F;
    localparam logic [7:0] TYPE_WAIT_LO = 8'h12;
    localparam logic [7:0] TYPE_WAIT_HI = 8'h15;

    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] slot;
    } t_emit_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_port;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_port;

endpackage

// File: sv/sfscp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfscp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfscp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/sfscp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfscp_parser
// Header hunt, payload store writes, running sum and checksum check.
// ----------------------------------------------------------------------------
module sfscp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    output sfscp_pkg::t_wr_port  o_wr,
    output sfscp_pkg::t_emit_req o_req
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_SYNC1 = 2'd1;
    localparam logic [1:0] PH_TYPE  = 2'd2;
    localparam logic [1:0] PH_DATA  = 2'd3;

    localparam logic [sfscp_pkg::CNT_W-1:0] CNT_FULL =
        sfscp_pkg::CNT_W'(sfscp_pkg::PAYLOAD_BYTES);
    localparam logic [sfscp_pkg::SLOT_W-1:0] SLOT_MAX =
        sfscp_pkg::SLOT_W'(sfscp_pkg::FRAME_SLOTS - 1);

    logic [1:0]                     r_phase, n_phase;
    logic [sfscp_pkg::CNT_W-1:0]    r_count, n_count;
    logic [7:0]                     r_sum, n_sum;
    logic [sfscp_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic                           w_full;
    logic                           w_match;

    assign w_full  = (r_count >= CNT_FULL);
    assign w_match = (r_sum == i_rx_byte);

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_sum       = r_sum;
        n_slot      = r_slot;
        o_wr.en     = 1'b0;
        o_wr.addr   = r_count[sfscp_pkg::ADDR_W-1:0];
        o_wr.data   = i_rx_byte;
        o_req.start = 1'b0;
        o_req.slot  = r_slot;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    n_phase = (i_rx_byte == sfscp_pkg::SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
                end
                PH_SYNC1: begin
                    n_phase = (i_rx_byte == sfscp_pkg::SYNC_SECOND) ? PH_TYPE : PH_HUNT;
                end
                PH_TYPE: begin
                    if (i_rx_byte == sfscp_pkg::TYPE_DATA) begin
                        n_phase = PH_DATA;
                        n_sum   = 8'd0;
                        n_count = '0;
                    end else if (i_rx_byte inside
                                 {[sfscp_pkg::TYPE_WAIT_LO:sfscp_pkg::TYPE_WAIT_HI]}) begin
                        n_phase = PH_TYPE;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (w_full) begin
                        n_phase = PH_HUNT;
                        n_sum   = 8'd0;
                        n_count = '0;
                        if (w_match) begin
                            o_req.start = 1'b1;
                            n_slot      = (r_slot == SLOT_MAX) ? '0 : r_slot + 1'b1;
                        end
                    end else begin
                        o_wr.en = 1'b1;
                        n_sum   = r_sum + i_rx_byte;
                        n_count = r_count + 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_sum   <= 8'd0;
            r_slot  <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_slot  <= n_slot;
        end
    end

endmodule

// File: sv/sfscp_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfscp_emitter
// Walks the payload store after a good frame and drives the result items.
// ----------------------------------------------------------------------------
module sfscp_emitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfscp_pkg::t_emit_req                i_req,
    output sfscp_pkg::t_rd_port                 o_rd,
    input  logic [7:0]                          i_rd_data,
    output logic                                o_busy,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sfscp_pkg::CHANNEL_W-1:0]     o_channel,
    output logic [sfscp_pkg::SAMPLE_W-1:0]      o_sample,
    output logic [sfscp_pkg::FRAME_SLOT_W-1:0]  o_frame_slot,
    output logic                                o_last
);

    localparam logic [sfscp_pkg::ADDR_W-1:0] ADDR_LAST =
        sfscp_pkg::ADDR_W'(sfscp_pkg::PAYLOAD_BYTES - 1);

    logic                           r_valid, n_valid;
    logic [sfscp_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [sfscp_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic                           w_last;
    logic                           w_take;

    assign w_last = (r_addr == ADDR_LAST);
    assign w_take = r_valid && i_ready;

    always_comb begin
        n_valid    = r_valid;
        n_addr     = r_addr;
        n_slot     = r_slot;
        o_rd.en    = 1'b0;
        o_rd.addr  = r_addr + 1'b1;
        if (i_req.start) begin
            n_valid   = 1'b1;
            n_addr    = '0;
            n_slot    = i_req.slot;
            o_rd.en   = 1'b1;
            o_rd.addr = '0;
        end else if (w_take) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_addr  = r_addr + 1'b1;
                o_rd.en = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_addr  <= '0;
        end else begin
            r_valid <= n_valid;
            r_addr  <= n_addr;
        end
        r_slot <= n_slot;
    end

    assign o_busy       = r_valid;
    assign o_valid      = r_valid;
    assign o_channel    = sfscp_pkg::CHANNEL_W'(r_addr);
    assign o_sample     = i_rd_data;
    assign o_frame_slot = sfscp_pkg::FRAME_SLOT_W'(r_slot);
    assign o_last       = w_last;

endmodule

// File: sv/sample_frame_sync_checksum_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_frame_sync_checksum_parser_unit
// Sync-header frame parser with 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while parsing: it hunts for 0x55 0xAA 0x0F
// (after any wait bytes 0x12 to 0x15), writes the 32 payload bytes into the
// payload RAM and keeps their 8-bit sum. When the byte after the payload
// matches the sum, the 32 samples are read from the RAM read port one per
// cycle unless the output stalls and leave through the output register with
// channel, frame slot and last mark; input ready is low meanwhile. A bad frame
// is dropped with no output. The RAM needs no clearing after reset.
module sample_frame_sync_checksum_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sfscp_pkg::RX_BYTE_W-1:0]     i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sfscp_pkg::CHANNEL_W-1:0]     o_channel,
    output logic [sfscp_pkg::SAMPLE_W-1:0]      o_sample,
    output logic [sfscp_pkg::FRAME_SLOT_W-1:0]  o_frame_slot,
    output logic                                o_last
);

    sfscp_pkg::t_wr_port  w_wr;
    sfscp_pkg::t_rd_port  w_rd;
    sfscp_pkg::t_emit_req w_req;
    logic [7:0]           w_rd_data;
    logic                 w_busy;
    logic                 w_accept;

    assign o_ready  = !w_busy;
    assign w_accept = i_valid && o_ready;

    sfscp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_wr      (w_wr),
        .o_req     (w_req)
    );

    sfscp_ram #(
        .DEPTH (sfscp_pkg::PAYLOAD_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr.en),
        .i_wr_addr (w_wr.addr),
        .i_wr_data (w_wr.data),
        .i_rd_en   (w_rd.en),
        .i_rd_addr (w_rd.addr),
        .o_rd_data (w_rd_data)
    );

    sfscp_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .o_rd         (w_rd),
        .i_rd_data    (w_rd_data),
        .o_busy       (w_busy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_channel    (o_channel),
        .o_sample     (o_sample),
        .o_frame_slot (o_frame_slot),
        .o_last       (o_last)
    );

endmodule
